[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the gradient noise block.
// Needs clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, off while reset is held.
`define GND_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, off while reset is held.
`define GND_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/gnd_pkg.sv]
// Shared types and fixed constants of the gradient noise block.
// No dependencies.
package gnd_pkg;
  localparam int DIM_W    = 3;
  localparam int IDX_W    = 8;
  localparam int PERM_W   = 8;
  localparam int COORD_W  = 32;
  localparam int OUT_W    = 19;
  localparam int OUT_MAX  = 262143;
  localparam int OUT_MIN  = -262144;
  localparam int AXES     = 4;
  localparam int CORNERS  = 16;

  localparam logic REQ_EVAL = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  localparam logic [DIM_W-1:0] DIM_2     = 3'd2;
  localparam logic [DIM_W-1:0] DIM_3     = 3'd3;
  localparam logic [DIM_W-1:0] DIM_4     = 3'd4;
  localparam logic [DIM_W-1:0] DIM_RESET = DIM_3;

  typedef logic [PERM_W-1:0]         perm_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [DIM_W-1:0]          dim_t;
endpackage

[rtl/gnd_perm_ram.sv]
// Permutation table memory: one write port, one registered read port.
// Depends on gnd_pkg.
module gnd_perm_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  gnd_pkg::perm_t wdata,
  input  logic [AW-1:0]  raddr,
  output gnd_pkg::perm_t rdata
);
  import gnd_pkg::*;

  perm_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/gradient_noise_2d_3d_4d_top.sv]
// Each evaluate beat runs the fade of every axis, then the table hash of every corner, then the
// pairwise interpolations and the saturating output register; one item at a time.
// Throughput is set by the single shared multiplier and the one table read port.
// Load beats write the table when accepted. Reset (rst_n, synchronous) clears control, sets dimension 3;
// the permutation table is undefined until written.
`include "assert_macros.svh"
module gradient_noise_2d_3d_4d_top #(
  parameter int TABLE_SIZE = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  gnd_pkg::dim_t                 cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [gnd_pkg::IDX_W-1:0]     in_table_index,
  input  gnd_pkg::perm_t                in_table_value,
  input  gnd_pkg::coord_t               in_coord_x,
  input  gnd_pkg::coord_t               in_coord_y,
  input  gnd_pkg::coord_t               in_coord_z,
  input  gnd_pkg::coord_t               in_coord_w,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [gnd_pkg::OUT_W-1:0] out_noise_value
);
  import gnd_pkg::*;

  localparam int TW = $clog2(TABLE_SIZE);
  localparam int F  = FRAC_BITS;
  localparam int GW = F + 4;
  localparam int MW = F + 6;
  localparam int PW = 2 * MW;
  localparam int QW = F + 5;
  localparam logic signed [GW-1:0] ONE_G  = GW'(64'sd1 << F);
  localparam logic signed [PW-1:0] HALF_P = PW'(64'sd1 << (F - 1));

  typedef enum logic [3:0] {
    S_IDLE, S_F1, S_F2, S_F3, S_F4, S_HASH, S_L1, S_L2, S_OUT
  } state_t;

  state_t                  state_r;
  dim_t                    dim_cfg_r;
  dim_t                    dims_r;
  logic [1:0]              ax_r;
  logic [TW-1:0]           cell_r [AXES];
  logic [F-1:0]            frac_r [AXES];
  logic [F:0]              fd_r   [AXES];
  logic [QW-1:0]           q_r;
  logic signed [PW-1:0]    mul_r;
  logic [2:0]              s_r;
  logic [3:0]              c_r;
  logic signed [GW-1:0]    g_r [CORNERS];
  logic [4:0]              fill_r;
  logic [1:0]              lk_r;
  logic [3:0]              lvl_r;
  logic [3:0]              cnt_r;
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_noise_r;

  logic                    in_accept;
  logic                    ram_we;
  logic [TW-1:0]           raddr;
  perm_t                   rd;
  logic signed [MW-1:0]    mul_a, mul_b;
  logic signed [PW-1:0]    p_val;
  logic signed [GW-1:0]    comp [AXES];
  logic signed [GW-1:0]    lerp_res;
  logic signed [31:0]      sat_x;
  dim_t                    dims_in;
  coord_t                  coord_in [AXES];
  logic [3:0]              last_c;

  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v);
    rnd = (v + HALF_P) >>> F;
  endfunction

  function automatic logic [TW-1:0] cell_of(input coord_t c);
    logic [63:0] ext;
    logic [63:0] sh;
    ext = {{32{c[COORD_W-1]}}, c};
    sh  = ext >> F;
    cell_of = sh[TW-1:0];
  endfunction

  function automatic logic signed [GW-1:0] grad(
    input perm_t h, input dim_t d,
    input logic signed [GW-1:0] x, input logic signed [GW-1:0] y,
    input logic signed [GW-1:0] z, input logic signed [GW-1:0] w);
    logic [4:0] hh;
    logic signed [GW-1:0] a, b, c;
    hh = h[4:0];
    a = x;
    b = y;
    c = z;
    grad = '0;
    if (d == DIM_2) begin
      case (h[2:0])
        3'd0:    grad = x + y;
        3'd1:    grad = -x + y;
        3'd2:    grad = x - y;
        3'd3:    grad = -x - y;
        3'd4:    grad = x;
        3'd5:    grad = -x;
        3'd6:    grad = y;
        default: grad = -y;
      endcase
    end else if (d == DIM_3) begin
      hh = {1'b0, h[3:0]};
      a = (hh < 5'd8) ? x : y;
      b = (hh < 5'd4) ? y : ((hh == 5'd12 || hh == 5'd14) ? x : z);
      grad = (h[0] ? -a : a) + (h[1] ? -b : b);
    end else begin
      a = (hh < 5'd24) ? x : y;
      b = (hh < 5'd16) ? y : z;
      c = (hh < 5'd8) ? z : w;
      grad = (h[0] ? -a : a) + (h[1] ? -b : b) + (h[2] ? -c : c);
    end
  endfunction

  assign in_stall        = (state_r != S_IDLE);
  assign in_accept       = in_valid && !in_stall;
  assign ram_we          = in_accept && (in_req_type == REQ_LOAD);
  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_r;

  assign dims_in = (dim_cfg_r <= DIM_2) ? DIM_2 : ((dim_cfg_r >= DIM_4) ? DIM_4 : DIM_3);
  assign coord_in[0] = in_coord_x;
  assign coord_in[1] = in_coord_y;
  assign coord_in[2] = in_coord_z;
  assign coord_in[3] = in_coord_w;
  assign last_c = 4'((5'd1 << dims_r) - 5'd1);

  always_comb begin
    if (s_r == 3'd0) begin
      raddr = cell_r[0] + TW'(c_r[0]);
    end else begin
      raddr = TW'(rd) + cell_r[s_r[1:0]] + TW'(c_r[s_r[1:0]]);
    end
  end

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      comp[k] = $signed({{(GW-F){1'b0}}, frac_r[k]}) - (c_r[k] ? ONE_G : GW'(0));
    end
  end

  always_comb begin
    mul_a = $signed(MW'(frac_r[ax_r]));
    mul_b = $signed(MW'(frac_r[ax_r]));
    case (state_r)
      S_F2: begin
        mul_a = MW'(rnd(mul_r));
      end
      S_F3: begin
        mul_a = MW'(rnd(mul_r));
        mul_b = $signed(MW'(q_r));
      end
      S_L1: begin
        mul_a = $signed(MW'(fd_r[lk_r]));
        mul_b = MW'(g_r[1]) - MW'(g_r[0]);
      end
      default: begin
      end
    endcase
  end

  assign p_val = PW'(6) * mul_r
               - PW'(15) * (PW'(frac_r[ax_r]) <<< F)
               + (PW'(10) <<< (2 * F));
  assign lerp_res = g_r[0] + GW'(rnd(mul_r));
  assign sat_x    = 32'(g_r[0]);

  gnd_perm_ram #(
    .DEPTH (TABLE_SIZE),
    .AW    (TW)
  ) u_perm (
    .clk   (clk),
    .we    (ram_we),
    .waddr (TW'(in_table_index)),
    .wdata (in_table_value),
    .raddr (raddr),
    .rdata (rd)
  );

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    if (in_accept && in_req_type == REQ_EVAL) begin
      for (int k = 0; k < AXES; k++) begin
        cell_r[k] <= cell_of(coord_in[k]);
        frac_r[k] <= coord_in[k][F-1:0];
      end
    end
    if (state_r == S_F2) begin
      q_r <= QW'(rnd(p_val));
    end
    if (state_r == S_F4) begin
      fd_r[ax_r] <= (F+1)'(rnd(mul_r));
    end
    if (state_r == S_HASH && s_r == dims_r) begin
      g_r[fill_r[3:0]] <= grad(rd, dims_r, comp[0], comp[1], comp[2], comp[3]);
    end
    if (state_r == S_L2) begin
      for (int i = 0; i < CORNERS; i++) begin
        if (4'(i) == 4'(fill_r - 5'd2)) begin
          g_r[i] <= lerp_res;
        end else if (i < CORNERS - 2) begin
          g_r[i] <= g_r[(i + 2) % CORNERS];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dim_cfg_r   <= DIM_RESET;
      dims_r      <= DIM_3;
      ax_r        <= '0;
      s_r         <= '0;
      c_r         <= '0;
      fill_r      <= '0;
      lk_r        <= '0;
      lvl_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      out_noise_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        dim_cfg_r <= cfg_wr_data;
      end
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_accept && in_req_type == REQ_EVAL) begin
            dims_r  <= dims_in;
            ax_r    <= '0;
            state_r <= S_F1;
          end
        end
        S_F1: state_r <= S_F2;
        S_F2: state_r <= S_F3;
        S_F3: state_r <= S_F4;
        S_F4: begin
          if ({1'b0, ax_r} == dims_r - 3'd1) begin
            s_r     <= '0;
            c_r     <= '0;
            fill_r  <= '0;
            state_r <= S_HASH;
          end else begin
            ax_r    <= ax_r + 2'd1;
            state_r <= S_F1;
          end
        end
        S_HASH: begin
          if (s_r == dims_r) begin
            s_r    <= '0;
            c_r    <= c_r + 4'd1;
            fill_r <= fill_r + 5'd1;
            if (c_r == last_c) begin
              lk_r    <= '0;
              lvl_r   <= 4'(5'd1 << (dims_r - 3'd1));
              cnt_r   <= 4'(5'd1 << (dims_r - 3'd1));
              state_r <= S_L1;
            end
          end else begin
            s_r <= s_r + 3'd1;
          end
        end
        S_L1: state_r <= S_L2;
        S_L2: begin
          fill_r <= fill_r - 5'd1;
          if (cnt_r == 4'd1) begin
            lk_r  <= lk_r + 2'd1;
            lvl_r <= lvl_r >> 1;
            cnt_r <= lvl_r >> 1;
          end else begin
            cnt_r <= cnt_r - 4'd1;
          end
          state_r <= (fill_r == 5'd2) ? S_OUT : S_L1;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            if (sat_x > OUT_MAX) begin
              out_noise_r <= OUT_W'(OUT_MAX);
            end else if (sat_x < OUT_MIN) begin
              out_noise_r <= OUT_W'(OUT_MIN);
            end else begin
              out_noise_r <= OUT_W'(sat_x);
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `GND_ASSERT_NXT(a_eval_starts_fade, in_accept && in_req_type == REQ_EVAL, state_r == S_F1 && ax_r == 2'd0, "evaluate beat did not start the fade sequence")
  `GND_ASSERT_NOW(a_push_no_overflow, state_r == S_HASH && s_r == dims_r, fill_r < 5'd16, "gradient queue overflow")
  `GND_ASSERT_NOW(a_lerp_has_pair, state_r == S_L1 || state_r == S_L2, fill_r >= 5'd2, "interpolation with fewer than two queued values")
  `GND_ASSERT_NXT(a_out_loads_once, state_r == S_OUT && (!out_valid_r || !out_stall), out_valid_r && state_r == S_IDLE, "result beat not presented")
endmodule
